@@ rtl/additive_checksum_fold_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the additive checksum fold block.
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ADDITIVE_CHECKSUM_FOLD_ASSERT_SVH
`define ADDITIVE_CHECKSUM_FOLD_ASSERT_SVH

// plain property, checked every cycle out of reset
`define ACF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ACF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/acf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acf_pkg
// Shared types, constants and helper functions of the checksum fold block.
// ---------------------------------------------------------------------------
package acf_pkg;

  localparam int MAX_WORD_BYTES = 8;
  localparam int SUM_W          = 64;
  localparam int BYTE_W         = 8;
  localparam int SIZE_W         = 4;
  localparam int LANE_W         = 3;
  localparam int CFG_AW         = 2;
  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_AW        = 1;
  localparam int FIFO_CW        = 2;

  typedef enum logic [CFG_AW-1:0] {
    CFG_INIT   = 2'd0,
    CFG_WORD   = 2'd1,
    CFG_RESULT = 2'd2,
    CFG_FOLD   = 2'd3
  } cfg_idx_t;

  // effective (clamped) configuration seen by front and back
  typedef struct packed {
    logic [SIZE_W-1:0] wb;
    logic [SIZE_W-1:0] rb;
    logic              fold_en;
  } acf_cfg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_PASS
  } back_state_t;

  // zero counts as one, anything above the max counts as the max
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(MAX_WORD_BYTES)) r = SIZE_W'(MAX_WORD_BYTES);
    else r = v;
    return r;
  endfunction

  // ones in the low nbytes bytes, nbytes in 1..8
  function automatic logic [SUM_W-1:0] low_mask(input logic [SIZE_W-1:0] nbytes);
    logic [SUM_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      if (SIZE_W'(i) < nbytes) m[i*BYTE_W +: BYTE_W] = '1;
    end
    return m;
  endfunction

  // (lane + 1) mod wb by repeated subtraction, wb in 1..8
  function automatic logic [LANE_W-1:0] lane_next(input logic [LANE_W-1:0] lane,
                                                  input logic [SIZE_W-1:0] wb);
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(lane) + SIZE_W'(1);
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      if (r >= wb) r = r - wb;
    end
    return r[LANE_W-1:0];
  endfunction

endpackage

@@ rtl/additive_checksum_fold.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// additive_checksum_fold
// Additive byte checksum with optional end-around fold, stream in and out.
// ---------------------------------------------------------------------------
// Bytes enter one per cycle on the in_ stream and are added, shifted by
// 8 * lane, into a 64-bit accumulator; lane counts modulo word_bytes. A word
// with in_tlast high closes the message: its sum is pushed into a two-entry
// queue and the front rearms at once. The back end pops a sum and, if
// fold_enable is set and both sizes are below 8, folds it: each fold pass
// adds the word_bytes-wide chunks through one shared 64-bit adder, one chunk
// per cycle. A sum costs one pop, one check per pass and a final check that
// loads the output register. The truncated result sits in that register until
// out_tready. Intake stalls while two sums are queued, which happens when
// messages close faster than the back end drains them. Registers written on
// cfg_we: 0 initial_value, 1 word_bytes, 2 result_bytes, 3 fold_enable. Write
// them while no message result is pending; no clearing pass after reset.
// ---------------------------------------------------------------------------
module additive_checksum_fold (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [acf_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic                         in_tlast,   // last_byte
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [acf_pkg::SUM_W-1:0]    out_tdata,  // [63:0] checksum
  // configuration writes
  input  logic                         cfg_we,
  input  logic [acf_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [acf_pkg::SUM_W-1:0]    cfg_wdata
);
  import acf_pkg::*;

  // raw register contents, clamped below
  logic [SUM_W-1:0]  init_r;
  logic [SIZE_W-1:0] word_bytes_r;
  logic [SIZE_W-1:0] result_bytes_r;
  logic              fold_en_r;
  acf_cfg_t          cfg;

  logic              init_load;
  logic              q_push, q_pop, q_empty, q_full;
  logic [SUM_W-1:0]  q_data, q_head;

  assign init_load = cfg_we && (cfg_addr == CFG_INIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r         <= '0;
      word_bytes_r   <= SIZE_W'(1);
      result_bytes_r <= SIZE_W'(1);
      fold_en_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_INIT:   init_r         <= cfg_wdata;
        CFG_WORD:   word_bytes_r   <= cfg_wdata[SIZE_W-1:0];
        CFG_RESULT: result_bytes_r <= cfg_wdata[SIZE_W-1:0];
        CFG_FOLD:   fold_en_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.wb      = eff_size(word_bytes_r);
    cfg.rb      = eff_size(result_bytes_r);
    cfg.fold_en = fold_en_r;
  end

  // front: accumulate bytes and hand on closed sums
  acf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .init_value      (init_r),
    .init_load       (init_load),
    .init_load_value (cfg_wdata),
    .byte_valid      (in_tvalid),
    .byte_data       (in_tdata),
    .byte_last       (in_tlast),
    .q_full          (q_full),
    .byte_ready      (in_tready),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  // queue of closed message sums
  acf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: fold, truncate, present result
  acf_fold u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ rtl/acf_fifo.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acf_fifo
// Short queue of finished message sums between front and back.
// ---------------------------------------------------------------------------
module acf_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [acf_pkg::SUM_W-1:0] push_data,
  input  logic                    pop,
  output logic [acf_pkg::SUM_W-1:0] head,
  output logic                    empty,
  output logic                    full
);
  import acf_pkg::*;

  logic [SUM_W-1:0]   mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/acf_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acf_front
// Byte intake: lane-shifted accumulate, hands the sum on at the last byte.
// ---------------------------------------------------------------------------
module acf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  acf_pkg::acf_cfg_t         cfg,
  input  logic [acf_pkg::SUM_W-1:0] init_value,
  input  logic                      init_load,
  input  logic [acf_pkg::SUM_W-1:0] init_load_value,
  input  logic                      byte_valid,
  input  logic [acf_pkg::BYTE_W-1:0] byte_data,
  input  logic                      byte_last,
  input  logic                      q_full,
  output logic                      byte_ready,
  output logic                      q_push,
  output logic [acf_pkg::SUM_W-1:0] q_data
);
  import acf_pkg::*;

  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic              in_msg_r, in_msg_nxt;
  logic [SUM_W-1:0]  sum_add;
  logic              take;

  assign byte_ready = !q_full;
  assign take       = byte_valid && byte_ready;
  assign sum_add    = acc_r + (SUM_W'(byte_data) << {lane_r, 3'b000});
  assign q_push     = take && byte_last;
  assign q_data     = sum_add;

  always_comb begin
    acc_nxt    = acc_r;
    lane_nxt   = lane_r;
    in_msg_nxt = in_msg_r;
    if (take) begin
      if (byte_last) begin
        acc_nxt    = init_value;
        lane_nxt   = '0;
        in_msg_nxt = 1'b0;
      end else begin
        acc_nxt    = sum_add;
        lane_nxt   = lane_next(lane_r, cfg.wb);
        in_msg_nxt = 1'b1;
      end
    end else if (init_load && !in_msg_r) begin
      // between messages a new start value takes effect at once
      acc_nxt = init_load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      lane_r   <= '0;
      in_msg_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      lane_r   <= lane_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

endmodule

@@ rtl/acf_fold.sv @@
`timescale 1ns / 1ps
`include "additive_checksum_fold_assert.svh"
// ---------------------------------------------------------------------------
// acf_fold
// End-around fold sequencer, one chunk add per cycle, and output register.
// ---------------------------------------------------------------------------
module acf_fold (
  input  logic                      clk,
  input  logic                      rst_n,
  input  acf_pkg::acf_cfg_t         cfg,
  input  logic                      q_empty,
  input  logic [acf_pkg::SUM_W-1:0] q_head,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [acf_pkg::SUM_W-1:0] out_tdata
);
  import acf_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [SUM_W-1:0]  val_r, val_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [LANE_W-1:0] off_r, off_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_data_r, out_data_nxt;
  logic [SUM_W-1:0]  chunk, chunk_sum;
  logic [SIZE_W-1:0] off_adv;
  logic              need_fold, out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign chunk     = (val_r >> {off_r, 3'b000}) & low_mask(cfg.wb);
  assign chunk_sum = total_r + chunk;
  assign off_adv   = SIZE_W'(off_r) + cfg.wb;
  assign need_fold = cfg.fold_en
                  && (cfg.wb < SIZE_W'(MAX_WORD_BYTES))
                  && (cfg.rb < SIZE_W'(MAX_WORD_BYTES))
                  && (val_r > low_mask(cfg.rb))
                  && (val_r > low_mask(cfg.wb));

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    total_nxt     = total_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          val_nxt   = q_head;
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        if (need_fold) begin
          total_nxt = '0;
          off_nxt   = '0;
          state_nxt = B_PASS;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = val_r & low_mask(cfg.rb);
          state_nxt     = B_IDLE;
        end
      end
      B_PASS: begin
        if (off_adv >= SIZE_W'(MAX_WORD_BYTES)) begin
          val_nxt   = chunk_sum;
          state_nxt = B_CHECK;
        end else begin
          total_nxt = chunk_sum;
          off_nxt   = off_adv[LANE_W-1:0];
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    total_r    <= total_nxt;
    off_r      <= off_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ACF_ASSERT_IMP(a_out_trunc, out_valid_r, (out_data_r & ~low_mask(cfg.rb)) == '0,
                  "checksum has bytes above result width")
  `ACF_ASSERT_IMP(a_pass_fold_en, state_r == B_PASS,
                  cfg.fold_en && (cfg.wb < SIZE_W'(MAX_WORD_BYTES)),
                  "fold pass without folding enabled")
  `ACF_ASSERT_IMP(a_pop_idle, q_pop, state_r == B_IDLE && !q_empty,
                  "queue popped while busy")
  `ACF_ASSERT_NXT(a_pop_check, q_pop, state_r == B_CHECK,
                  "popped sum not checked next cycle")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for additive_checksum_fold: a directed sequence of
// register writes and message words, then randomized phases of messages,
// each checksum scored against the plan or an in-bench model of the sum and fold.
// ---------------------------------------------------------------------------
module testbench;
  import acf_pkg::*;

  localparam int RAND_WORDS  = 1750;    // random message words to send
  localparam int CALM_WORDS  = 200;     // final stretch with no idling
  localparam int FOLD_TAIL   = 16;      // settle cycles before a register write
  localparam int END_TAIL    = 64;      // watch for stray results at the end
  localparam int CYCLE_LIMIT = 500000;  // watchdog
  localparam int REPORT_CAP  = 100;     // printed mismatch lines

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  // one step of the directed sequence; value is the register data or, for a
  // word, the byte in [7:0]; want is only used when known is set
  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    sel;
    logic [63:0] value;
    logic        last;
    logic        known;
    logic [63:0] want;
  } plan_row_t;

  localparam int PLAN_LEN = 37;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset settings: one byte lanes, one result byte, no fold
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b1, 1'b1, 64'hFF},
    '{ROW_WORD, CFG_INIT,   64'h00,   1'b1, 1'b1, 64'h00},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b1, 1'b1, 64'hFE},
    // full 64-bit words, full result: eight 0xFF bytes fill every lane
    '{ROW_CFG,  CFG_WORD,   64'd8,    1'b0, 1'b0, 64'h0},
    '{ROW_CFG,  CFG_RESULT, 64'd8,    1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    // initial value loaded between messages, and the sum wraps to zero
    '{ROW_CFG,  CFG_INIT,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'h01,   1'b1, 1'b1, 64'h0},
    // word size 0 acts as 1, result size 15 acts as 8, so no fold
    '{ROW_CFG,  CFG_INIT,   64'h0,    1'b0, 1'b0, 64'h0},
    '{ROW_CFG,  CFG_WORD,   64'd0,    1'b0, 1'b0, 64'h0},
    '{ROW_CFG,  CFG_RESULT, 64'd15,   1'b0, 1'b0, 64'h0},
    '{ROW_CFG,  CFG_FOLD,   64'd1,    1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'h80,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'h80,   1'b1, 1'b1, 64'h100},
    // word size 15 acts as 8 (no fold), result size 0 acts as 1
    '{ROW_CFG,  CFG_WORD,   64'd15,   1'b0, 1'b0, 64'h0},
    '{ROW_CFG,  CFG_RESULT, 64'd0,    1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'h12,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'h34,   1'b1, 1'b1, 64'h12},
    // 16-bit end-around carry: 0xFFFF + 0xFFFF folds to 0xFFFF
    '{ROW_CFG,  CFG_WORD,   64'd2,    1'b0, 1'b0, 64'h0},
    '{ROW_CFG,  CFG_RESULT, 64'd2,    1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hFF,   1'b1, 1'b1, 64'hFFFF},
    // 3-byte chunks: the top chunk runs past bit 63
    '{ROW_CFG,  CFG_WORD,   64'd3,    1'b0, 1'b0, 64'h0},
    '{ROW_CFG,  CFG_RESULT, 64'd1,    1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hA5,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'h5A,   1'b0, 1'b0, 64'h0},
    '{ROW_WORD, CFG_INIT,   64'hC3,   1'b1, 1'b0, 64'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tlast;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;   // [63:0] checksum
  logic        cfg_we;
  cfg_idx_t    cfg_addr;
  logic [63:0] cfg_wdata;

  // model state: register copies and the running message
  logic [63:0] m_init = '0;
  logic [3:0]  m_word = 4'd1;
  logic [3:0]  m_result = 4'd1;
  logic        m_fold = 1'b0;
  logic [63:0] m_acc = '0;
  logic [2:0]  m_lane = '0;
  logic        m_open = 1'b0;   // a byte of the current message was taken

  logic [63:0] sums_due [$];    // checksums still to arrive, oldest first
  int          errors = 0;
  int          cycle_count = 0;
  int          gap_pct = 0;     // sender idle odds, percent per word
  int          stall_pct = 0;   // receiver stall odds, percent per cycle
  int          stall_left = 0;
  bit          calm = 1'b0;     // final stretch: no idling on either side

  additive_checksum_fold i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- checksum model --------------------------------------------------

  // register size in bytes: 0 counts as 1, above 8 counts as 8
  function automatic int clamp_size(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return int'(v);
  endfunction

  function automatic logic [63:0] byte_mask(input int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // one fold pass: sum of n-byte chunks, bytes past bit 63 read as zero
  function automatic logic [63:0] fold_chunks(input logic [63:0] v, input int n);
    logic [63:0] total;
    total = '0;
    for (int off = 0; off < 8; off += n) begin
      total += (v >> (8 * off)) & byte_mask(n);
    end
    return total;
  endfunction

  function automatic void note_cfg(input cfg_idx_t sel, input logic [63:0] v);
    case (sel)
      CFG_INIT: begin
        m_init = v;
        // takes effect now only between messages
        if (!m_open) m_acc = v;
      end
      CFG_WORD:   m_word = v[3:0];
      CFG_RESULT: m_result = v[3:0];
      CFG_FOLD:   m_fold = v[0];
      default: ;
    endcase
  endfunction

  // add one byte into the running sum; on the last byte, close the message
  task automatic add_byte(input logic [7:0] d, input logic l, output bit closes,
                          output logic [63:0] sum);
    int wb;
    int rb;
    wb = clamp_size(m_word);
    rb = clamp_size(m_result);
    m_acc  = m_acc + (64'(d) << (8 * m_lane));
    m_lane = 3'((m_lane + 1) % wb);
    m_open = 1'b1;
    closes = l;
    sum = '0;
    if (l) begin
      sum = m_acc;
      // fold only when both sizes are short of the full 64 bits
      if (m_fold && wb < 8 && rb < 8) begin
        while (sum > byte_mask(rb) && sum > byte_mask(wb)) sum = fold_chunks(sum, wb);
      end
      sum = sum & byte_mask(rb);
      m_acc  = m_init;
      m_lane = '0;
      m_open = 1'b0;
    end
  endtask

  // ---- drivers ---------------------------------------------------------

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    if (errors < REPORT_CAP)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one word; tasks enter and leave at a falling edge
  task automatic put_word(input logic [7:0] d, input logic l, input bit known,
                          input logic [63:0] want);
    bit          closes;
    logic [63:0] sum;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    add_byte(d, l, closes, sum);
    if (closes) sums_due = {sums_due, (known ? want : sum)};
    @(negedge clk);
  endtask

  // write one register; the enable drops before the next write can start
  task automatic set_reg(input cfg_idx_t sel, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    note_cfg(sel, v);
    @(negedge clk);
  endtask

  // hold intake until every checksum is out and the fold engine is quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(negedge clk);
    repeat (FOLD_TAIL) @(negedge clk);
  endtask

  // ---- receiver and scoreboard ------------------------------------------

  // ready drops in bursts of random length, never in the final stretch
  always @(negedge clk) begin
    if (!calm && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sums_due.size() == 0) report("checksum with none due", out_tdata, '0);
      else if (out_tdata !== sums_due[0]) report("checksum", out_tdata, sums_due.pop_front());
      else void'(sums_due.pop_front());
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d checksums pending",
               cycle_count, sums_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- stimulus ----------------------------------------------------------

  initial begin
    int          words_sent;
    int          phase_end;
    int          first;
    int          len;
    int          pick;
    cfg_idx_t    sel;
    logic [63:0] v;
    logic [7:0]  b;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_INIT;
    cfg_wdata  = '0;
    words_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sequence, reset settings first; writes only once drained
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        if (i == 0 || PLAN[i-1].kind != ROW_CFG) settle();
        set_reg(PLAN[i].sel, PLAN[i].value);
      end else begin
        put_word(PLAN[i].value[7:0], PLAN[i].last, PLAN[i].known, PLAN[i].want);
      end
    end

    // random phases: drain, new settings, then whole messages
    while (words_sent < RAND_WORDS) begin
      calm = (words_sent >= RAND_WORDS - CALM_WORDS);
      // the final stretch keeps the last settings and runs without pauses
      if (!calm) begin
        settle();
        first = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          sel = cfg_idx_t'((first + k) % 4);
          v = {$urandom, $urandom};   // unused upper bits stay random
          case (sel)
            CFG_INIT: begin
              pick = $urandom_range(0, 3);
              if (pick == 0) v = '0;
              else if (pick == 1) v = '1;
            end
            CFG_WORD, CFG_RESULT: begin
              // mostly legal sizes, sometimes 0 or above 8
              if ($urandom_range(0, 7) == 0) v[3:0] = 4'($urandom_range(0, 15));
              else v[3:0] = 4'($urandom_range(1, 8));
            end
            default: v[0] = ($urandom_range(0, 3) != 0);  // fold mostly on
          endcase
          set_reg(sel, v);
        end

        // idle odds per phase; zero now and then leaves stretches without gaps
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
      end
      phase_end = words_sent + $urandom_range(40, 160);

      while (words_sent < phase_end && words_sent < RAND_WORDS) begin
        calm = (words_sent >= RAND_WORDS - CALM_WORDS);
        pick = $urandom_range(0, 19);
        if (pick < 14) len = $urandom_range(1, 8);
        else if (pick < 19) len = $urandom_range(9, 32);
        else len = $urandom_range(33, 90);
        for (int j = 0; j < len; j++) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) b = 8'hFF;
          else if (pick == 1) b = 8'h00;
          else b = 8'($urandom);
          put_word(b, j == len - 1, 1'b0, '0);
          words_sent++;
        end
        // now and then hold the sender until all checksums are back
        if (!calm && $urandom_range(0, 49) == 0) settle();
      end
    end

    in_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(negedge clk);
    repeat (END_TAIL) @(negedge clk);
    if (sums_due.size() != 0)
      report("checksums never delivered", 64'(sums_due.size()), '0);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
